### hdl/ptach_pkg.sv
// ----------------------------------------------------------------------------
// ptach_pkg
// Shared constants, types and controller/datapath links for the pulse
// tachometer with moving-average interval filter.
// ----------------------------------------------------------------------------
package ptach_pkg;

  localparam int RING_DEPTH = 8;
  localparam int IDX_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int TS_W       = 32;
  localparam int SUM_W      = TS_W + $clog2(RING_DEPTH);
  localparam int PPR_W      = 8;
  localparam int PERIOD_W   = 16;
  localparam int SCALE_W    = 16;
  localparam int RPM_W      = 16;
  localparam int DVS_W      = PPR_W + TS_W;
  localparam int CNT_W      = $clog2(SUM_W + 1);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);

  localparam logic [CFG_IDX_W-1:0] CFG_PPR    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 2'd2;

  localparam logic [PPR_W-1:0]    RST_PPR    = 8'd1;
  localparam logic [PERIOD_W-1:0] RST_PERIOD = 16'd1000;
  localparam logic [SCALE_W-1:0]  RST_SCALE  = SCALE_W'(60 * 1000);

  localparam logic OP_EDGE = 1'b0;
  localparam logic OP_POLL = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SUM_RD,
    ST_SUM_ACC,
    ST_AVG_LD,
    ST_MUL,
    ST_RPM_LD,
    ST_DIV_RPM,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic cap;
    logic edge_wr;
    logic poll_upd;
    logic rd;
    logic acc;
    logic avg_ld;
    logic div_step;
    logic mul;
    logic rpm_ld;
    logic out_ld;
  } cmd_t;

  typedef struct packed {
    logic is_poll;
    logic early;
    logic idx_last;
    logic div_done;
    logic out_busy;
  } sts_t;

endpackage

### hdl/ptach_if.sv
// ----------------------------------------------------------------------------
// ptach_in_if / ptach_out_if
// Valid/ready channels for events in and speed results out.
// ----------------------------------------------------------------------------
interface ptach_in_if;
  import ptach_pkg::*;
  logic            valid;
  logic            ready;
  logic            opcode;
  logic [TS_W-1:0] now_ms;

  modport source (output valid, output opcode, output now_ms, input ready);
  modport sink   (input valid, input opcode, input now_ms, output ready);
endinterface

interface ptach_out_if;
  import ptach_pkg::*;
  logic             valid;
  logic             ready;
  logic [RPM_W-1:0] rpm;

  modport source (output valid, output rpm, input ready);
  modport sink   (input valid, input rpm, output ready);
endinterface

### hdl/ptach_ctrl.sv
// ----------------------------------------------------------------------------
// ptach_ctrl
// Sequencer: edge write, poll gate, ring sweep, serial divide, output.
// ----------------------------------------------------------------------------
module ptach_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  ptach_pkg::sts_t sts,
  output ptach_pkg::cmd_t cmd
);
  import ptach_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (!sts.is_poll) begin
          cmd.edge_wr = 1'b1;
          state_nxt   = ST_IDLE;
        end else if (sts.early) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.poll_upd = 1'b1;
          state_nxt    = ST_SUM_RD;
        end
      end
      ST_SUM_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_SUM_ACC;
      end
      ST_SUM_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = sts.idx_last ? ST_AVG_LD : ST_SUM_RD;
      end
      ST_AVG_LD: begin
        cmd.avg_ld = 1'b1;
        state_nxt  = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_RPM_LD;
      end
      ST_RPM_LD: begin
        cmd.rpm_ld = 1'b1;
        state_nxt  = ST_DIV_RPM;
      end
      ST_DIV_RPM: begin
        if (sts.div_done) begin
          state_nxt = ST_OUT;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_OUT: begin
        if (!sts.out_busy) begin
          cmd.out_ld = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### hdl/ptach_dp.sv
// ----------------------------------------------------------------------------
// ptach_dp
// Datapath: config registers, interval ring, accumulator, restoring divider,
// multiplier and output register.
// ----------------------------------------------------------------------------
module ptach_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_opcode,
  input  logic [ptach_pkg::TS_W-1:0]       in_now_ms,
  input  logic                             cfg_we,
  input  logic [ptach_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [ptach_pkg::CFG_DATA_W-1:0] cfg_data,
  input  ptach_pkg::cmd_t                  cmd,
  output ptach_pkg::sts_t                  sts,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [ptach_pkg::RPM_W-1:0]      out_rpm
);
  import ptach_pkg::*;

  logic [PPR_W-1:0]    ppr_r;
  logic [PERIOD_W-1:0] period_r;
  logic [SCALE_W-1:0]  scale_r;

  logic                op_r;
  logic [TS_W-1:0]     now_r;
  logic [TS_W-1:0]     last_edge_r;
  logic [TS_W-1:0]     last_upd_r;
  logic [IDX_W-1:0]    slot_r;
  logic [IDX_W-1:0]    idx_r;
  logic [RING_DEPTH-1:0] vld_r;
  logic [TS_W-1:0]     ring_mem [RING_DEPTH];
  logic [TS_W-1:0]     rd_data_r;
  logic                rd_ok_r;
  logic [SUM_W-1:0]    acc_r;

  logic [SUM_W-1:0]    dvd_r;
  logic [DVS_W-1:0]    dvs_r;
  logic [DVS_W-1:0]    rem_r;
  logic [CNT_W-1:0]    cnt_r;

  logic                out_valid_r;
  logic [RPM_W-1:0]    rpm_r;

  logic [TS_W-1:0]     interval;
  logic [TS_W-1:0]     since_upd;
  logic [DVS_W:0]      trial;
  logic                q_bit;

  assign interval  = now_r - last_edge_r;
  assign since_upd = now_r - last_upd_r;
  assign trial     = {rem_r, dvd_r[SUM_W-1]};
  assign q_bit     = (trial >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ppr_r    <= RST_PPR;
      period_r <= RST_PERIOD;
      scale_r  <= RST_SCALE;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_PPR:    ppr_r    <= cfg_data[PPR_W-1:0];
        CFG_PERIOD: period_r <= cfg_data[PERIOD_W-1:0];
        CFG_SCALE:  scale_r  <= cfg_data[SCALE_W-1:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_edge_r <= '0;
      last_upd_r  <= '0;
      slot_r      <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.edge_wr) begin
        last_edge_r    <= now_r;
        vld_r[slot_r]  <= 1'b1;
        slot_r         <= (slot_r == LAST_IDX) ? '0 : slot_r + IDX_W'(1);
      end
      if (cmd.poll_upd) begin
        last_upd_r <= now_r;
      end
      if (cmd.out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.edge_wr) begin
      ring_mem[slot_r] <= interval;
    end
    if (cmd.rd) begin
      rd_data_r <= ring_mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      op_r  <= in_opcode;
      now_r <= in_now_ms;
    end
    if (cmd.rd) begin
      rd_ok_r <= vld_r[idx_r];
    end
    if (cmd.poll_upd) begin
      acc_r <= '0;
      idx_r <= '0;
    end else if (cmd.acc) begin
      acc_r <= acc_r + (rd_ok_r ? SUM_W'(rd_data_r) : '0);
      idx_r <= (idx_r == LAST_IDX) ? '0 : idx_r + IDX_W'(1);
    end
    if (cmd.avg_ld) begin
      dvd_r <= acc_r / SUM_W'(RING_DEPTH);
    end else if (cmd.mul) begin
      dvs_r <= DVS_W'(ppr_r) * DVS_W'(dvd_r[TS_W-1:0]);
    end else if (cmd.rpm_ld) begin
      dvd_r <= {scale_r, {(SUM_W - SCALE_W){1'b0}}};
      rem_r <= '0;
      cnt_r <= CNT_W'(SCALE_W);
    end else if (cmd.div_step) begin
      rem_r <= q_bit ? trial[DVS_W-1:0] - dvs_r : trial[DVS_W-1:0];
      dvd_r <= {dvd_r[SUM_W-2:0], q_bit};
      cnt_r <= cnt_r - CNT_W'(1);
    end
    if (cmd.out_ld) begin
      rpm_r <= (dvs_r == '0) ? '0 : dvd_r[RPM_W-1:0];
    end
  end

  assign sts.is_poll  = (op_r == OP_POLL);
  assign sts.early    = (since_upd < TS_W'(period_r));
  assign sts.idx_last = (idx_r == LAST_IDX);
  assign sts.div_done = (cnt_r == '0);
  assign sts.out_busy = out_valid_r && !out_ready;

  assign out_valid = out_valid_r;
  assign out_rpm   = rpm_r;

endmodule

### hdl/pulse_tachometer_moving_avg.sv
// ----------------------------------------------------------------------------
// pulse_tachometer_moving_avg
// Pulse tachometer: ring of recent edge intervals, averaged on poll into rpm.
//
//   port     dir  transaction
//   in_ch    in   opcode (edge/poll) + now_ms timestamp
//   out_ch   out  rpm, one per poll that passes the update period
//   cfg_*    in   register write: pulses_per_rev, update_period_ms, rate_scale
//
// An edge is captured and then written into the ring; a poll inside the update
// period is dropped after capture. A passing poll sweeps the ring (a read and
// an accumulate per entry), loads the average, multiplies and runs the one-bit-per-cycle rpm divider.
// One item at a time; the output register lets the next item in while a
// result waits, and a new result holds until that register frees up.
// Synchronous active-low reset clears ring valid bits and time stores.
// ----------------------------------------------------------------------------
module pulse_tachometer_moving_avg (
  input  logic                             clk,
  input  logic                             rst_n,
  ptach_in_if.sink                         in_ch,
  ptach_out_if.source                      out_ch,
  input  logic                             cfg_we,
  input  logic [ptach_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [ptach_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ptach_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ptach_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ptach_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_opcode (in_ch.opcode),
    .in_now_ms (in_ch.now_ms),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_rpm   (out_ch.rpm)
  );

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the pulse tachometer. Edges and polls stream in
// under random gaps while the result side stalls at random. Each event is
// scored against an in-bench copy of the interval ring, the time stores and
// the rpm divide, and each rpm transaction is compared with the oldest
// expected value. Every register is reprogrammed between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import ptach_pkg::*;

  localparam int LIMIT_CYCLES = 1_500_000;
  localparam int DRAIN_CYCLES = 120;
  localparam int LONG_HOLD    = 500;
  localparam int PHASE_EVENTS = 250;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct {
    logic            opcode;
    logic [TS_W-1:0] now_ms;
  } tach_event_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  ptach_in_if  in_ch();
  ptach_out_if out_ch();

  pulse_tachometer_moving_avg dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch.sink),
    .out_ch   (out_ch.source),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  tach_event_t          pending_events[$];
  logic [RPM_W-1:0]     expected_rpm[$];

  logic [TS_W-1:0]      ring[RING_DEPTH];
  logic [IDX_W-1:0]     slot;
  logic [TS_W-1:0]      last_edge_ms;
  logic [TS_W-1:0]      last_update_ms;
  logic [PPR_W-1:0]     ppr_reg;
  logic [PERIOD_W-1:0]  period_reg;
  logic [SCALE_W-1:0]   scale_reg;

  int   errors;
  int   cycles;
  int   rpm_seen;
  int   gap_left;
  int   hold_left;
  int   gap_roll;
  int   stall_roll;
  logic gaps_on;
  logic stalls_on;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function void track_event(logic op, logic [TS_W-1:0] now);
    logic [SUM_W-1:0]  sum;
    logic [TS_W-1:0]   avg;
    logic [DVS_W-1:0]  divisor;
    logic [DVS_W-1:0]  quotient;
    if (op == OP_EDGE) begin
      ring[slot]   = now - last_edge_ms;
      last_edge_ms = now;
      slot         = (slot == LAST_IDX) ? '0 : slot + 1'b1;
      return;
    end
    if ((now - last_update_ms) < TS_W'(period_reg))
      return;
    last_update_ms = now;
    sum = '0;
    for (int k = 0; k < RING_DEPTH; k++)
      sum += SUM_W'(ring[k]);
    avg      = TS_W'(sum / RING_DEPTH);
    divisor  = DVS_W'(ppr_reg) * DVS_W'(avg);
    quotient = (divisor == '0) ? '0 : DVS_W'(scale_reg) / divisor;
    expected_rpm.push_back(quotient[RPM_W-1:0]);
  endfunction

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      gap_left    <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        track_event(in_ch.opcode, in_ch.now_ms);
      if (in_ch.valid && !in_ch.ready) begin
      end else if (gap_left != 0) begin
        gap_left    <= gap_left - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_events.size() != 0) begin
        tach_event_t ev;
        ev = pending_events.pop_front();
        in_ch.valid  <= 1'b1;
        in_ch.opcode <= ev.opcode;
        in_ch.now_ms <= ev.now_ms;
        gap_roll = $urandom_range(0, 99);
        if (!gaps_on || gap_roll < 55)
          gap_left <= 0;
        else if (gap_roll < 90)
          gap_left <= $urandom_range(1, 3);
        else if (gap_roll < 98)
          gap_left <= $urandom_range(4, 20);
        else
          gap_left <= $urandom_range(30, 80);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left    <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        rpm_seen++;
        if (expected_rpm.size() == 0) begin
          $error("rpm: no transaction expected, actual %0d", out_ch.rpm);
          errors++;
        end else begin
          logic [RPM_W-1:0] want;
          want = expected_rpm.pop_front();
          if (out_ch.rpm !== want) begin
            $error("rpm: expected %0d, actual %0d", want, out_ch.rpm);
            errors++;
          end
        end
      end
      if (out_ch.valid && out_ch.ready && rpm_seen % 300 == 40) begin
        hold_left    <= LONG_HOLD;
        out_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left    <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else if (!stalls_on) begin
        out_ch.ready <= 1'b1;
      end else begin
        stall_roll = $urandom_range(0, 99);
        if (stall_roll < 65) begin
          out_ch.ready <= 1'b1;
        end else if (stall_roll < 95) begin
          out_ch.ready <= 1'b0;
        end else begin
          out_ch.ready <= 1'b0;
          hold_left    <= $urandom_range(5, 40);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic push_event(logic op, logic [TS_W-1:0] now);
    tach_event_t ev;
    ev.opcode = op;
    ev.now_ms = now;
    pending_events.push_back(ev);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    case (idx)
      CFG_PPR:    ppr_reg    = data[PPR_W-1:0];
      CFG_PERIOD: period_reg = data[PERIOD_W-1:0];
      CFG_SCALE:  scale_reg  = data[SCALE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [PPR_W-1:0] ppr, logic [PERIOD_W-1:0] period,
                            logic [SCALE_W-1:0] scale);
    cfg_write(CFG_PPR, CFG_DATA_W'(ppr));
    cfg_write(CFG_UNUSED, CFG_DATA_W'($urandom));
    cfg_write(CFG_PERIOD, period);
    cfg_write(CFG_SCALE, scale);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    while (pending_events.size() != 0 || in_ch.valid || expected_rpm.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    logic [TS_W-1:0]     t;
    logic [PPR_W-1:0]    ppr;
    logic [PERIOD_W-1:0] period;
    logic [SCALE_W-1:0]  scale;
    int                  step_max;

    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = '0;
    cfg_data     = '0;
    in_ch.valid  = 1'b0;
    in_ch.opcode = OP_EDGE;
    in_ch.now_ms = '0;
    out_ch.ready = 1'b0;
    errors       = 0;
    cycles       = 0;
    rpm_seen     = 0;
    gaps_on      = 1'b0;
    stalls_on    = 1'b0;
    for (int k = 0; k < RING_DEPTH; k++)
      ring[k] = '0;
    slot           = '0;
    last_edge_ms   = '0;
    last_update_ms = '0;
    ppr_reg        = RST_PPR;
    period_reg     = RST_PERIOD;
    scale_reg      = RST_SCALE;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // defaults: early poll, poll on an empty ring, wrapping timestamps
    push_event(OP_POLL, 32'd0);
    push_event(OP_POLL, 32'd1000);
    for (int i = 1; i <= 8; i++)
      push_event(OP_EDGE, TS_W'(1000 + 100 * i));
    push_event(OP_POLL, 32'd1999);
    push_event(OP_POLL, 32'd2000);
    push_event(OP_EDGE, 32'hFFFF_FFF0);
    push_event(OP_EDGE, 32'h0000_0010);
    push_event(OP_EDGE, 32'h0000_0010);
    push_event(OP_POLL, 32'h0000_0400);
    push_event(OP_POLL, 32'hFFFF_FFFF);
    wait_idle();

    // zero period, largest quotient
    set_config(8'd1, 16'd0, 16'd65535);
    for (int i = 1; i <= 9; i++)
      push_event(OP_EDGE, TS_W'(5000 + i));
    push_event(OP_POLL, 32'd5009);
    push_event(OP_POLL, 32'd5009);
    wait_idle();

    t = 32'd6000;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin ppr = 8'd1;   period = 16'd0;     scale = 16'd65535; end
        1: begin ppr = 8'd255; period = 16'd65535; scale = 16'd1;     end
        2: begin ppr = 8'd1;   period = 16'd65535; scale = 16'd65535; end
        3: begin ppr = 8'd255; period = 16'd0;     scale = 16'd65535; end
        default: begin
          ppr    = PPR_W'($urandom_range(1, 255));
          period = PERIOD_W'($urandom_range(0, 300));
          scale  = SCALE_W'($urandom_range(1, 65535));
        end
      endcase
      set_config(ppr, period, scale);
      gaps_on   = (ph % 3 != 0);
      stalls_on = (ph % 4 != 1);
      step_max  = int'(period) / 4 + 8;
      for (int n = 0; n < PHASE_EVENTS; n++) begin
        if ($urandom_range(0, 99) < 2)
          t = $urandom;
        else
          t = t + TS_W'($urandom_range(0, step_max));
        push_event(($urandom_range(0, 99) < 60) ? OP_EDGE : OP_POLL, t);
      end
      wait_idle();
    end

    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

### filelist.f
hdl/ptach_pkg.sv
hdl/ptach_if.sv
hdl/ptach_ctrl.sv
hdl/ptach_dp.sv
hdl/pulse_tachometer_moving_avg.sv
sim/testbench.sv
